>>> hw/rtl/rcli_pkg.sv
// Shared types and constants for the rate curve interpolator.
// Used by rcli_table, rcli_div and the top level; depends on nothing.
package rcli_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int TIME_W = 24;
  localparam int RATE_W = 32;
  localparam int SUM_W  = RATE_W + 3;

  // Divider sizing: |product| < 2^56, quotient magnitude < 2^33, divisor < 2^24
  localparam int DIVN_W = 56;
  localparam int DIVQ_W = 33;
  localparam int DIVD_W = 24;
  localparam int DIVC_W = $clog2(DIVQ_W + 1);

  localparam logic [RATE_W-1:0] RATE_ONE = 32'h0100_0000;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NEG_TIME = 2'd1,
    STS_DUP_TIME = 2'd2,
    STS_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_DEC,
    S_Q_LAST,
    S_Q_FIRST,
    S_Q_SCAN,
    S_Q_MUL,
    S_Q_DIV_GO,
    S_Q_DIV_WAIT,
    S_Q_FIX,
    S_DONE
  } rcli_state_e;

  typedef struct packed {
    logic                     func;
    logic signed [TIME_W-1:0] point_time;
    logic signed [RATE_W-1:0] point_rate;
    logic signed [TIME_W-1:0] query_time;
  } rcli_in_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_value;
    logic [1:0]               status;
  } rcli_out_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] pt_time;
    logic signed [RATE_W-1:0] pt_rate;
  } rcli_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } rcli_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVQ_W-1:0] quotient;
  } rcli_div_rsp_t;

endpackage

>>> hw/rtl/rate_curve_linear_interpolator.sv
// Rate curve interpolator top level: sequencer, scan, multiply and result stage.
// Depends on rcli_pkg, rcli_table and rcli_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one item per
//   transfer: func selects insert (append a time/rate point) or query (rate at
//   query_time). Output channel (out_valid_o / out_stall_i / out_data_o) gives
//   exactly one result per item, in order.
//   Items are processed one at a time; in_stall_o is high from the transfer
//   until the result enters the output register.
//   Insert: the duplicate check does one table read per stored point.
//   Query: run time is set by the point scan (one table read per cycle) and
//   the 33-step divider; an empty table or a time outside the curve skips both.
//   The output register holds a result while out_stall_i is high; the next
//   item is accepted meanwhile and waits in its final state for the slot.
//   Reset empties the table (point count to zero) and drops any pending result.
module rate_curve_linear_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rcli_pkg::rcli_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rcli_pkg::rcli_out_t out_data_o
);
  import rcli_pkg::*;

  function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({4'b0000, {(RATE_W-1){1'b1}}});
    lo = $signed({4'b1111, {(RATE_W-1){1'b0}}});
    if (v > hi) begin
      return hi[RATE_W-1:0];
    end else if (v < lo) begin
      return lo[RATE_W-1:0];
    end
    return v[RATE_W-1:0];
  endfunction

  rcli_state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  rcli_in_t           item_q, item_d;
  logic               dup_q, dup_d;
  rcli_entry_t        last_q, last_d;
  rcli_entry_t        prev_q, prev_d;
  logic signed [TIME_W:0]      dtq_q, dtq_d;
  logic signed [TIME_W:0]      dt_q, dt_d;
  logic signed [RATE_W:0]      dr_q, dr_d;
  logic signed [TIME_W+RATE_W+1:0] prod_q, prod_d;
  logic               neg_q, neg_d;
  rcli_out_t          res_q, res_d;
  rcli_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  rcli_entry_t        rd_data;
  rcli_entry_t        wr_data;
  logic               wr_en;
  rcli_div_req_t      div_req;
  rcli_div_rsp_t      div_rsp;

  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   last_idx;
  logic               at_last;
  logic               t_le_rd;
  logic               t_ge_last;
  logic               match;
  logic               out_free;
  logic [TIME_W+RATE_W+1:0] prod_mag;
  logic [DIVQ_W-1:0]  qmag;
  logic signed [DIVQ_W:0] qs;
  logic signed [RATE_W-1:0] qsat;

  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign last_idx  = cnt_m1[IDX_W-1:0];
  assign at_last   = (idx_q == last_idx);
  assign t_le_rd   = (item_q.query_time <= rd_data.pt_time);
  assign t_ge_last = (item_q.query_time >= last_q.pt_time);
  assign match     = (rd_data.pt_time == item_q.point_time);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign prod_mag = prod_q[TIME_W+RATE_W+1] ? ('0 - prod_q) : prod_q;
  assign qmag     = (dt_q == '0) ? '0 : div_rsp.quotient;
  assign qs       = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign qsat     = sat_rate(SUM_W'(qs));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.func == FUNC_QUERY) begin
            state_d = (cnt_q == '0) ? S_DONE : S_Q_LAST;
          end else begin
            state_d = (cnt_q == '0) ? S_INS_DEC : S_INS_SCAN;
          end
        end
      end
      S_INS_SCAN:   if (at_last) state_d = S_INS_DEC;
      S_INS_DEC:    state_d = S_DONE;
      S_Q_LAST:     state_d = S_Q_FIRST;
      S_Q_FIRST:    state_d = (t_le_rd || t_ge_last) ? S_DONE : S_Q_SCAN;
      S_Q_SCAN:     if (t_le_rd || at_last) state_d = S_Q_MUL;
      S_Q_MUL:      state_d = S_Q_DIV_GO;
      S_Q_DIV_GO:   state_d = (dt_q == '0) ? S_Q_FIX : S_Q_DIV_WAIT;
      S_Q_DIV_WAIT: if (div_rsp.done) state_d = S_Q_FIX;
      S_Q_FIX:      state_d = S_DONE;
      S_DONE:       if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    item_d      = item_q;
    dup_d       = dup_q;
    last_d      = last_q;
    prev_d      = prev_q;
    dtq_d       = dtq_q;
    dt_d        = dt_q;
    dr_d        = dr_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_mag[DIVN_W-1:0];
    div_req.divisor  = dt_q[DIVD_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          dup_d  = 1'b0;
          // table read is registered, so the address is set ahead of the check
          idx_d  = (in_data_i.func == FUNC_QUERY) ? last_idx : '0;
          res_d  = '{rate_value: RATE_ONE, status: STS_OK};
        end
      end
      S_INS_SCAN: begin
        dup_d = dup_q | match;
        idx_d = idx_q + IDX_W'(1);
      end
      S_INS_DEC: begin
        res_d.rate_value = '0;
        if (item_q.point_time < 0) begin
          res_d.status = STS_NEG_TIME;
        end else if (dup_q) begin
          res_d.status = STS_DUP_TIME;
        end else if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
          res_d.status = STS_FULL;
        end else begin
          res_d.status = STS_OK;
          wr_en        = 1'b1;
          cnt_d        = cnt_q + CNT_W'(1);
        end
      end
      S_Q_LAST: begin
        last_d = rd_data;
        idx_d  = '0;
      end
      S_Q_FIRST: begin
        if (t_le_rd) begin
          res_d.rate_value = rd_data.pt_rate;
        end else if (t_ge_last) begin
          res_d.rate_value = last_q.pt_rate;
        end else begin
          prev_d = rd_data;
          idx_d  = IDX_W'(1);
        end
      end
      S_Q_SCAN: begin
        if (t_le_rd || at_last) begin
          dtq_d = (TIME_W+1)'(item_q.query_time) - (TIME_W+1)'(prev_q.pt_time);
          dt_d  = (TIME_W+1)'(rd_data.pt_time) - (TIME_W+1)'(prev_q.pt_time);
          dr_d  = (RATE_W+1)'(rd_data.pt_rate) - (RATE_W+1)'(prev_q.pt_rate);
        end else begin
          prev_d = rd_data;
          idx_d  = idx_q + IDX_W'(1);
        end
      end
      S_Q_MUL: begin
        prod_d = dtq_q * dr_q;
      end
      S_Q_DIV_GO: begin
        div_req.start = (dt_q != '0);
        neg_d         = prod_q[TIME_W+RATE_W+1];
      end
      S_Q_DIV_WAIT: ;
      S_Q_FIX: begin
        res_d.rate_value = sat_rate(SUM_W'(prev_q.pt_rate) + SUM_W'(qsat));
        res_d.status     = STS_OK;
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    item_q <= item_d;
    dup_q  <= dup_d;
    last_q <= last_d;
    prev_q <= prev_d;
    dtq_q  <= dtq_d;
    dt_q   <= dt_d;
    dr_q   <= dr_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign wr_data.pt_time = item_q.point_time;
  assign wr_data.pt_rate = item_q.point_rate;

  rcli_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (idx_d),
    .rd_data_o (rd_data)
  );

  rcli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted item did not start processing");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("point count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_INS_DEC))
    else $error("point count changed outside an insert decision");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_Q_DIV_WAIT))
    else $error("divider finished while sequencer not waiting");

endmodule

>>> hw/rtl/rcli_table.sv
// Curve point storage: one write port, one read port with registered data.
// Depends on rcli_pkg.
module rcli_table (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [rcli_pkg::IDX_W-1:0]      wr_addr_i,
  input  rcli_pkg::rcli_entry_t           wr_data_i,
  input  logic [rcli_pkg::IDX_W-1:0]      rd_addr_i,
  output rcli_pkg::rcli_entry_t           rd_data_o
);
  import rcli_pkg::*;

  rcli_entry_t mem [TABLE_DEPTH];
  rcli_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/rcli_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on rcli_pkg.
module rcli_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rcli_pkg::rcli_div_req_t req_i,
  output rcli_pkg::rcli_div_rsp_t rsp_o
);
  import rcli_pkg::*;

  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DIVQ_W-1:0] quo_q, quo_d;
  logic [DIVD_W-1:0] dvs_q, dvs_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DIVD_W:0] trial;
  logic [DIVD_W:0] diff;
  logic            fits;

  assign trial = {rem_q, quo_q[DIVQ_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // high dividend bits are known to be below the divisor
      rem_d  = DIVD_W'(req_i.dividend[DIVN_W-1:DIVQ_W]);
      quo_d  = req_i.dividend[DIVQ_W-1:0];
      dvs_d  = req_i.divisor;
      cnt_d  = DIVC_W'(DIVQ_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      quo_d = {quo_q[DIVQ_W-2:0], fits};
      cnt_d = cnt_q - DIVC_W'(1);
      if (cnt_q == DIVC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule
